[hdl/bba_pkg.sv]
package bba_pkg;

  // Map geometry. WORD_BITS is a power of two so that a block number splits
  // into a word index (upper bits) and a bit index (lower bits).
  localparam int MAP_WORDS    = 48;
  localparam int WORD_BITS    = 16;
  localparam int MAX_RUN      = 64;
  localparam int TOTAL_BLOCKS = MAP_WORDS * WORD_BITS;
  localparam int RESET_FREE   = (MAP_WORDS - 1) * WORD_BITS;

  localparam int WORD_IDX_W = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);

  // Field widths fixed by the interface.
  localparam int CNT_W  = 7;
  localparam int BLK_W  = 10;
  localparam int CYL_W  = 6;
  localparam int FREE_W = 10;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_RANGE   = 2'd2,
    ST_ALREADY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_ALLOC    = 2'd0,
    K_FREE     = 2'd1,
    K_RUN_LONG = 2'd2,
    K_RANGE    = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [CNT_W-1:0] count;
    logic [BLK_W-1:0] blk;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [BLK_W-1:0]  blk;
    logic              last;
    logic [FREE_W-1:0] free_left;
  } res_t;

endpackage

[hdl/bba_front.sv]
module bba_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     func,
  input  logic [bba_pkg::CNT_W-1:0] count,
  input  logic [bba_pkg::BLK_W-1:0] block_number,
  output logic                     push_valid,
  input  logic                     push_ready,
  output bba_pkg::cmd_t            push_cmd
);
  import bba_pkg::*;

  logic fr_valid;
  cmd_t fr_cmd;
  cmd_t cmd_next;
  logic keep;

  assign in_ready   = !fr_valid || push_ready;
  assign push_valid = fr_valid;
  assign push_cmd   = fr_cmd;

  // Sort the request into the cases the back end handles. An allocate of
  // zero blocks produces nothing and is dropped here.
  always_comb begin
    cmd_next.count = count;
    cmd_next.blk   = block_number;
    keep           = 1'b1;
    if (func) begin
      if ({1'b0, block_number} < (BLK_W + 1)'(TOTAL_BLOCKS)) begin
        cmd_next.kind = K_FREE;
      end else begin
        cmd_next.kind = K_RANGE;
      end
    end else begin
      keep = (count != '0);
      if (count > CNT_W'(MAX_RUN)) begin
        cmd_next.kind = K_RUN_LONG;
      end else begin
        cmd_next.kind = K_ALLOC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      fr_valid <= keep;
    end else if (push_ready) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr_cmd <= cmd_next;
    end
  end

endmodule

[hdl/bba_queue.sv]
module bba_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  bba_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output bba_pkg::cmd_t pop_cmd
);
  import bba_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

[hdl/bba_back.sv]
module bba_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  bba_pkg::cmd_t pop_cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output bba_pkg::res_t res
);
  import bba_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_LOAD   = 6'b000100,
    S_SCAN   = 6'b001000,
    S_CHECK  = 6'b010000,
    S_REPORT = 6'b100000
  } state_t;

  state_t                state;
  state_t                state_next;
  cmd_t                  cmd;
  logic [WORD_IDX_W-1:0] w;
  logic [CNT_W-1:0]      n;
  logic [FREE_W-1:0]     free_count;
  word_t                 cur_word;
  status_t               rep_status;
  logic [BLK_W-1:0]      rep_blk;

  word_t                 map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]  map_valid;
  word_t                 rd_data;
  logic                  rd_valid;

  logic                  wr_en;
  word_t                 wr_data;
  logic                  res_load;
  res_t                  res_next;
  logic                  out_ok;
  logic                  shortage;
  word_t                 zero_bits;
  logic                  has_zero;
  logic [BIT_IDX_W-1:0]  first_zero;
  word_t                 grant_mask;
  word_t                 free_mask;
  logic                  run_last;

  assign out_ok     = !res_valid || res_ready;
  assign pop_ready  = (state == S_IDLE);
  assign shortage   = {{(FREE_W - CNT_W){1'b0}}, pop_cmd.count} > free_count;
  assign zero_bits  = ~cur_word;
  assign has_zero   = |zero_bits;
  assign grant_mask = word_t'(1) << first_zero;
  assign free_mask  = word_t'(1) << cmd.blk[BIT_IDX_W-1:0];
  assign run_last   = ((n + CNT_W'(1)) == cmd.count);

  // Lowest clear bit of the current map word.
  always_comb begin
    first_zero = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (zero_bits[i]) begin
        first_zero = BIT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_data    = cur_word;
    res_load   = 1'b0;
    res_next   = '0;
    case (state)
      S_IDLE: begin
        if (pop_valid) begin
          case (pop_cmd.kind)
            K_ALLOC: state_next = shortage ? S_REPORT : S_READ;
            K_FREE:  state_next = S_READ;
            default: state_next = S_REPORT;
          endcase
        end
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        state_next = (cmd.kind == K_ALLOC) ? S_SCAN : S_CHECK;
      end
      S_SCAN: begin
        if (!has_zero) begin
          wr_en      = 1'b1;
          state_next = S_READ;
        end else if (out_ok) begin
          res_load           = 1'b1;
          res_next.status    = ST_OK;
          res_next.blk       = BLK_W'({w, first_zero});
          res_next.last      = run_last;
          res_next.free_left = free_count - FREE_W'(1);
          if (run_last) begin
            wr_en      = 1'b1;
            wr_data    = cur_word | grant_mask;
            state_next = S_IDLE;
          end
        end
      end
      S_CHECK: begin
        if (out_ok) begin
          res_load      = 1'b1;
          res_next.blk  = cmd.blk;
          res_next.last = 1'b1;
          state_next    = S_IDLE;
          if ((cur_word & free_mask) == '0) begin
            res_next.status    = ST_ALREADY;
            res_next.free_left = free_count;
          end else begin
            wr_en              = 1'b1;
            wr_data            = cur_word & ~free_mask;
            res_next.status    = ST_OK;
            res_next.free_left = free_count + FREE_W'(1);
          end
        end
      end
      S_REPORT: begin
        if (out_ok) begin
          res_load           = 1'b1;
          res_next.status    = rep_status;
          res_next.blk       = rep_blk;
          res_next.last      = 1'b1;
          res_next.free_left = free_count;
          state_next         = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= FREE_W'(RESET_FREE);
      map_valid  <= '0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        map_valid[w] <= 1'b1;
      end
      if (state == S_SCAN && has_zero && out_ok) begin
        free_count <= free_count - FREE_W'(1);
      end else if (state == S_CHECK && out_ok && (cur_word & free_mask) != '0) begin
        free_count <= free_count + FREE_W'(1);
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (pop_valid) begin
          cmd        <= pop_cmd;
          n          <= '0;
          rep_status <= ST_SHORT;
          rep_blk    <= '0;
          case (pop_cmd.kind)
            K_ALLOC: w <= '0;
            K_FREE:  w <= WORD_IDX_W'(pop_cmd.blk >> BIT_IDX_W);
            K_RANGE: begin
              rep_status <= ST_RANGE;
              rep_blk    <= pop_cmd.blk;
            end
            default: rep_status <= ST_SHORT;
          endcase
        end
      end
      S_LOAD: begin
        // A word never written still holds its reset value.
        if (rd_valid) begin
          cur_word <= rd_data;
        end else if (w == '0) begin
          cur_word <= '1;
        end else begin
          cur_word <= '0;
        end
      end
      S_SCAN: begin
        if (!has_zero) begin
          w <= w + WORD_IDX_W'(1);
        end else if (out_ok) begin
          cur_word <= cur_word | grant_mask;
          n        <= n + CNT_W'(1);
        end
      end
      default: begin
        cur_word <= cur_word;
      end
    endcase
    if (res_load) begin
      res <= res_next;
    end
  end

  // Bitmap memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[w] <= wr_data;
    end
    rd_data  <= map_mem[w];
    rd_valid <= map_valid[w];
  end

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= FREE_W'(TOTAL_BLOCKS))
    else $error("free count above the number of blocks");

  a_free_only_with_result: assert property (@(posedge clk) disable iff (rst)
    !res_load |=> $stable(free_count))
    else $error("free count changed without a result");

  a_free_step: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (free_count == $past(free_count) ||
                  free_count == $past(free_count) + FREE_W'(1) ||
                  free_count == $past(free_count) - FREE_W'(1)))
    else $error("free count moved by more than one");

  a_scan_in_map: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ({1'b0, w} < (WORD_IDX_W + 1)'(MAP_WORDS)))
    else $error("allocation scan ran past the end of the map");

endmodule

[hdl/bitmap_block_allocator_unit.sv]
// Bitmap disk-block allocator with first-fit allocation.
//
// Requests enter on the s_* channel: tuser is the operation (0 allocate a
// run, 1 free one block), tdata carries the run length and the block number.
// Results leave on the m_* channel, one item per granted block for an
// allocation and one item for every other request; tlast marks the final
// item of a request and tuser carries the status code. An allocate of zero
// blocks is dropped and returns nothing.
//
// A front stage classifies each request and hands it through a two-entry
// queue to the back end, which owns the 48-word bitmap memory and carries
// requests out one at a time. In the back end a free is read, loaded,
// checked and reported, and a refusal goes straight to its report. An
// allocation takes the request, then reads and loads each map word in
// turn, steps past each full word and grants one block per scan step
// while the receiver takes results.
//
// Reset leaves word 0 reserved and all other blocks free (752). When the
// receiver stalls, the back end waits and the front and queue fill up first.
module bitmap_block_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [6:0] count, [16:7] block_number, [23:17] zero
  input  logic        s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [9:0] granted_block, [15:10] cylinder, [17:16] track,
                                 // [19:18] sector, [29:20] free_left, [31:30] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast
);
  import bba_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;
  res_t res;

  bba_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .func         (s_tuser),
    .count        (s_tdata[CNT_W-1:0]),
    .block_number (s_tdata[CNT_W+BLK_W-1:CNT_W]),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_cmd     (push_cmd)
  );

  bba_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  bba_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  // Cylinder, track and sector are plain slices of the registered block number.
  assign m_tdata = {2'b00,
                    res.free_left,
                    res.blk[1:0],
                    res.blk[3:2],
                    CYL_W'(res.blk >> BIT_IDX_W),
                    res.blk};
  assign m_tuser = res.status;
  assign m_tlast = res.last;

endmodule
